>>> rtl/utf16_to_utf8_transcoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define U16U8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define U16U8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Types, code range constants and the code point encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned MaxBytes = 6;

  localparam logic [15:0] HighFirst = 16'hd800;
  localparam logic [15:0] HighLast  = 16'hdbff;
  localparam logic [15:0] LowFirst  = 16'hdc00;
  localparam logic [15:0] LowLast   = 16'hdfff;
  localparam logic [15:0] TermZero  = 16'h0000;
  localparam logic [15:0] TermOnes  = 16'hffff;
  localparam logic [20:0] SuppBase  = 21'h10000;
  localparam logic [20:0] Lim1Byte  = 21'h80;
  localparam logic [20:0] Lim2Byte  = 21'h800;
  localparam logic [20:0] Lim3Byte  = 21'h10000;
  localparam logic [5:0]  HighTag   = 6'b110110;

  // Per-item decoder state
  typedef struct packed {
    logic [9:0] held_bits;
    logic       held_valid;
    logic       stopped;
  } u16u8_state_t;

  // Bytes of one item, first byte in entry 0; cnt is 0..6
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               cnt;
  } u16u8_res_t;

  // One encoded code point, 1..4 bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } u16u8_enc_t;

  function automatic u16u8_enc_t enc_point(input logic [20:0] cp);
    u16u8_enc_t r;
    r = '0;
    if (cp < Lim1Byte) begin
      r.bytes[0] = {1'b0, cp[6:0]};
      r.cnt      = 3'd1;
    end else if (cp < Lim2Byte) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp < Lim3Byte) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

>>> rtl/u16u8_decode.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 item decoder
// Turns one code unit plus the surrogate state into its UTF-8 bytes.
// ----------------------------------------------------------------------------
module u16u8_decode
  import u16u8_pkg::*;
(
  input  logic [15:0]  unit_i,
  input  logic         last_i,
  input  u16u8_state_t state_i,
  output u16u8_state_t state_o,
  output u16u8_res_t   res_o
);

  logic       is_high;
  logic       is_low;
  logic       is_term;
  logic [20:0] pair_cp;
  u16u8_enc_t held_enc;
  u16u8_enc_t pair_enc;
  u16u8_enc_t unit_enc;
  logic       flush;
  logic       consumed;
  logic [2:0] unit_cnt;

  assign is_high  = (unit_i >= HighFirst) && (unit_i <= HighLast);
  assign is_low   = (unit_i >= LowFirst) && (unit_i <= LowLast);
  assign is_term  = (unit_i == TermZero) || (unit_i == TermOnes);
  assign pair_cp  = SuppBase + {1'b0, state_i.held_bits, unit_i[9:0]};
  assign held_enc = enc_point({5'd0, HighTag, state_i.held_bits});
  assign pair_enc = enc_point(pair_cp);
  assign unit_enc = enc_point({5'd0, unit_i});

  always_comb begin
    state_o  = state_i;
    res_o    = '0;
    flush    = 1'b0;
    consumed = 1'b0;
    unit_cnt = 3'd0;
    if (!state_i.stopped) begin
      if (state_i.held_valid) begin
        state_o.held_valid = 1'b0;
        if (is_low) begin
          consumed = 1'b1;
        end else begin
          flush = 1'b1;
        end
      end
      if (!consumed) begin
        if (is_term) begin
          state_o.stopped = 1'b1;
        end else if (is_high && !last_i) begin
          state_o.held_bits  = unit_i[9:0];
          state_o.held_valid = 1'b1;
        end else begin
          unit_cnt = unit_enc.cnt;
        end
      end
      // assemble: pair, or held flush followed by the new unit, or new unit
      if (consumed) begin
        res_o.bytes[3:0] = pair_enc.bytes;
        res_o.cnt        = pair_enc.cnt;
      end else if (flush) begin
        res_o.bytes[2:0] = held_enc.bytes[2:0];
        res_o.bytes[5:3] = unit_enc.bytes[2:0];
        res_o.cnt        = 3'd3 + unit_cnt;
      end else begin
        res_o.bytes[3:0] = unit_enc.bytes;
        res_o.cnt        = unit_cnt;
      end
    end
    if (last_i) begin
      state_o = '0;
    end
  end

endmodule

>>> rtl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Streams UTF-16 code units in and UTF-8 bytes out, one byte per item.
// ----------------------------------------------------------------------------
// Each input item carries one UTF-16 code unit; the block answers with 1 to 6
// result items, one UTF-8 byte each, or one flags-only item when the unit
// produces no byte (held high surrogate, terminator, ignored unit). A high
// surrogate waits for the next unit: a following low surrogate completes a
// 4-byte code point, anything else flushes it as 3 bytes first. Units 0x0000
// and 0xffff end the name and later units are ignored until tlast. The input
// is registered, decoded in one pass into a six-byte result buffer, and the
// buffer shifts out one byte per cycle while the output is ready. The input
// register and then the result buffer lie between input accept and the first
// output byte. An item holds the output until all of its results (1 to 6)
// are taken; items with a single result stream at one per cycle while ready.
`include "utf16_to_utf8_transcoder_macros.svh"

module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item: tdata[15:0] = code_unit; tlast = unit_last
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tlast_i,   // unit_last
  // result item: tlast = run_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser_o,   // [0] byte_valid, [1] name_end
  output logic        m_axis_tlast_o    // run_last
);

  // Input register
  logic        in_valid_q;
  logic [15:0] in_unit_q;
  logic        in_last_q;

  // Surrogate / terminator state
  u16u8_state_t st_q, st_d;

  // Result buffer: entry 0 is the byte on the output
  logic                     rb_valid_q, rb_valid_d;
  logic [MaxBytes-1:0][7:0] rb_bytes_q, rb_bytes_d;
  logic [2:0]               rb_cnt_q, rb_cnt_d;
  logic                     rb_none_q, rb_none_d;
  logic                     rb_end_q, rb_end_d;

  u16u8_res_t dec_res;
  logic       take;
  logic       rb_final;
  logic       load;
  logic       in_take;

  u16u8_decode u_decode (
    .unit_i  (in_unit_q),
    .last_i  (in_last_q),
    .state_i (st_q),
    .state_o (st_d),
    .res_o   (dec_res)
  );

  assign take     = m_axis_tvalid_o && m_axis_tready_i;
  assign rb_final = (rb_cnt_q == 3'd1);
  // move the registered item into the buffer when it is empty or draining
  assign load     = in_valid_q && (!rb_valid_q || (take && rb_final));
  assign s_axis_tready_o = !in_valid_q || load;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o   = rb_valid_q;
  assign m_axis_tdata_o    = rb_bytes_q[0];
  assign m_axis_tlast_o    = rb_final;
  assign m_axis_tuser_o[0] = !rb_none_q;
  assign m_axis_tuser_o[1] = rb_final && rb_end_q;

  always_comb begin
    rb_valid_d = rb_valid_q;
    rb_bytes_d = rb_bytes_q;
    rb_cnt_d   = rb_cnt_q;
    rb_none_d  = rb_none_q;
    rb_end_d   = rb_end_q;
    if (load) begin
      rb_valid_d = 1'b1;
      rb_bytes_d = dec_res.bytes;
      rb_end_d   = in_last_q;
      if (dec_res.cnt == 3'd0) begin
        // no byte: one flags-only item, data held at zero
        rb_bytes_d = '0;
        rb_cnt_d   = 3'd1;
        rb_none_d  = 1'b1;
      end else begin
        rb_cnt_d  = dec_res.cnt;
        rb_none_d = 1'b0;
      end
    end else if (take) begin
      if (rb_final) begin
        rb_valid_d = 1'b0;
      end else begin
        // advance to the next byte
        for (int i = 0; i < MaxBytes - 1; i++) begin
          rb_bytes_d[i] = rb_bytes_q[i+1];
        end
        rb_bytes_d[MaxBytes-1] = '0;
        rb_cnt_d = rb_cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= '0;
      rb_valid_q <= 1'b0;
      rb_cnt_q   <= 3'd0;
      rb_none_q  <= 1'b0;
      rb_end_q   <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        st_q <= st_d;
      end
      rb_valid_q <= rb_valid_d;
      rb_cnt_q   <= rb_cnt_d;
      rb_none_q  <= rb_none_d;
      rb_end_q   <= rb_end_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_unit_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    rb_bytes_q <= rb_bytes_d;
  end

  `U16U8_ASSERT_NOW(a_cnt_nonzero, rb_valid_q, (rb_cnt_q != 3'd0) && (rb_cnt_q <= 3'd6), "result buffer holds a bad count")
  `U16U8_ASSERT_NOW(a_hold_stop_excl, 1'b1, !(st_q.held_valid && st_q.stopped), "surrogate held after terminator")
  `U16U8_ASSERT_NOW(a_flags_only_last, rb_valid_q && rb_none_q, rb_final, "flags-only item is not the last of its run")
  `U16U8_ASSERT_NEXT(a_run_continues, take && !rb_final, rb_valid_q, "run dropped before its last item")

endmodule

>>> tb/utf16_to_utf8_transcoder_test.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder testbench
// Streams names of UTF-16 code units into the transcoder and checks every
// UTF-8 result item against a predictor that tracks held surrogates and the
// stopped state. Both stream sides idle at random, and the result side holds
// off once for a long stretch so that the input back-pressures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_test
  import u16u8_pkg::*;
();

  // One UTF-8 result item as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       name_end;
  } utf8_result_t;

  // Tracks the decoder state, predicts the UTF-8 results of each accepted
  // code unit, and checks the result stream against them in order.
  class utf8_byte_scoreboard;
    logic [9:0]   held_bits;
    logic         held_valid;
    logic         stopped;
    utf8_result_t expected_bytes[$];
    utf8_result_t unit_bytes[$];
    int           units_in;
    int           mismatches;

    function new();
      held_bits  = '0;
      held_valid = 1'b0;
      stopped    = 1'b0;
      units_in   = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [7:0] b);
      utf8_result_t r;
      r.data       = b;
      r.byte_valid = 1'b1;
      r.run_last   = 1'b0;
      r.name_end   = 1'b0;
      unit_bytes = {unit_bytes, r};
    endfunction

    // Append the UTF-8 form of one code point, shortest encoding
    function void emit_point(logic [20:0] cp);
      if (cp < Lim1Byte) begin
        push_byte(cp[7:0]);
      end else if (cp < Lim2Byte) begin
        push_byte(8'hc0 | 8'(cp[10:6]));
        push_byte(8'h80 | 8'(cp[5:0]));
      end else if (cp < Lim3Byte) begin
        push_byte(8'he0 | 8'(cp[15:12]));
        push_byte(8'h80 | 8'(cp[11:6]));
        push_byte(8'h80 | 8'(cp[5:0]));
      end else begin
        push_byte(8'hf0 | 8'(cp[20:18]));
        push_byte(8'h80 | 8'(cp[17:12]));
        push_byte(8'h80 | 8'(cp[11:6]));
        push_byte(8'h80 | 8'(cp[5:0]));
      end
    endfunction

    // Work out the results of one accepted code unit and queue them
    function void note_unit(logic [15:0] unit, logic last);
      logic         is_high;
      logic         is_low;
      logic         paired;
      utf8_result_t r;
      is_high = (unit >= HighFirst) && (unit <= HighLast);
      is_low  = (unit >= LowFirst) && (unit <= LowLast);
      paired  = 1'b0;
      unit_bytes.delete();
      units_in++;
      if (!stopped) begin
        if (held_valid) begin
          held_valid = 1'b0;
          if (is_low) begin
            emit_point(SuppBase + 21'({held_bits, unit[9:0]}));
            paired = 1'b1;
          end else begin
            // Lone high surrogate goes out as a plain 3-byte unit
            emit_point(21'(HighFirst | 16'(held_bits)));
          end
        end
        if (!paired) begin
          if (unit == TermZero || unit == TermOnes) begin
            stopped = 1'b1;
          end else if (is_high && !last) begin
            held_bits  = unit[9:0];
            held_valid = 1'b1;
          end else begin
            emit_point(21'(unit));
          end
        end
      end
      if (unit_bytes.size() == 0) begin
        r = '0;
        unit_bytes = {unit_bytes, r};
      end
      unit_bytes[unit_bytes.size()-1].run_last = 1'b1;
      unit_bytes[unit_bytes.size()-1].name_end = last;
      foreach (unit_bytes[i]) expected_bytes = {expected_bytes, unit_bytes[i]};
      if (last) begin
        stopped    = 1'b0;
        held_valid = 1'b0;
        held_bits  = '0;
      end
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_byte(utf8_result_t got);
      utf8_result_t exp;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected item data=%02h flags=%03b",
                                  got.data, {got.byte_valid, got.run_last, got.name_end}));
      end else begin
        exp = expected_bytes.pop_front();
        if (got !== exp)
          report_mismatch($sformatf(
            "data=%02h/%02h byte_valid=%b/%b run_last=%b/%b name_end=%b/%b (got/exp)",
            got.data, exp.data, got.byte_valid, exp.byte_valid,
            got.run_last, exp.run_last, got.name_end, exp.name_end));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic [15:0] s_tdata;
  logic        s_tlast;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_tready;
  logic [7:0]  m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  utf8_byte_scoreboard sb;

  // Idle permissions, switched by the stimulus in stretches
  bit src_idle_ok;
  bit sink_idle_ok;
  bit long_hold_done;

  utf16_to_utf8_transcoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one code unit from a falling edge and hold it until accepted.
  // Return at the falling edge after the accepting rising edge.
  task automatic send_unit(input logic [15:0] unit, input logic last);
    if (src_idle_ok && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= unit;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_unit(unit, last);
    @(negedge clk_i);
  endtask

  // Build one name: mostly well-formed text with surrogate pairs, plus lone
  // surrogates, terminators and the odd name of raw noise.
  task automatic send_random_name();
    logic [15:0] units[$];
    int          len;
    bit          noisy;
    len   = $urandom_range(1, 10);
    noisy = ($urandom_range(0, 9) == 0);
    while (units.size() < len) begin
      if (noisy) begin
        units = {units, 16'($urandom)};
      end else begin
        case ($urandom_range(0, 11))
          0, 1: units = {units, 16'($urandom_range(1, 'h7f))};
          2: units = {units, 16'($urandom_range('h80, 'h7ff))};
          3: units = {units, 16'($urandom_range('h800, 'hd7ff))};
          4: units = {units, 16'($urandom_range('he000, 'hfffe))};
          5, 6, 7: begin
            units = {units, HighFirst | 16'($urandom_range(0, 'h3ff))};
            units = {units, LowFirst | 16'($urandom_range(0, 'h3ff))};
          end
          8: units = {units, HighFirst | 16'($urandom_range(0, 'h3ff))};
          9: units = {units, LowFirst | 16'($urandom_range(0, 'h3ff))};
          10: units = {units, 16'($urandom)};
          default: begin
            // Keep terminators rare so most names run to their end
            if ($urandom_range(0, 2) == 0)
              units = {units, ($urandom_range(0, 1) ? TermOnes : TermZero)};
            else
              units = {units, 16'($urandom_range(1, 'h7f))};
          end
        endcase
      end
    end
    foreach (units[i]) send_unit(units[i], i == units.size() - 1);
  endtask

  // Result side: drive tready at falling edges. Once enough input has gone
  // in, hold off for a long stretch so the block fills and stalls its input.
  initial begin
    m_tready       = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && sb != null && sb.units_in >= 150) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end else if (sink_idle_ok && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Sample results at the rising edge
  always @(posedge clk_i) begin
    utf8_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.data       = m_axis_tdata_o;
      got.byte_valid = m_axis_tuser_o[0];
      got.run_last   = m_axis_tlast_o;
      got.name_end   = m_axis_tuser_o[1];
      sb.check_byte(got);
    end
  end

  // Directed units, {unit_last, code_unit}
  logic [16:0] directed_units[$] = '{
    17'h1_0000,                           // terminator alone, marked last
    17'h0_007f, 17'h0_0080, 17'h0_07ff,   // 1- and 2-byte edges
    17'h0_0800, 17'h0_d7ff, 17'h0_e000,   // 3-byte edges around surrogates
    17'h1_fffe,
    17'h0_d800, 17'h1_dc00,               // lowest pair
    17'h0_dbff, 17'h0_dfff,               // highest pair
    17'h1_dbff,                           // high surrogate marked last
    17'h0_dc00,                           // lone low surrogate
    17'h0_d800, 17'h0_dbff, 17'h0_0041,   // high after high, then ASCII
    17'h0_d912, 17'h0_ffff,               // held high flushed by terminator
    17'h0_1234, 17'h0_d800, 17'h1_0000,   // ignored until last
    17'h1_0001                            // fresh name after the stop
  };

  initial begin
    int target;
    sb           = new();
    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    src_idle_ok  = 1'b1;
    sink_idle_ok = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_units[i]) send_unit(directed_units[i][15:0], directed_units[i][16]);

    // Random names; switch idling in stretches, none at all near the end
    target = sb.units_in + 440;
    while (sb.units_in < target) begin
      if (target - sb.units_in < 60) begin
        src_idle_ok  = 1'b0;
        sink_idle_ok = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        src_idle_ok  = ($urandom_range(0, 2) != 0);
        sink_idle_ok = ($urandom_range(0, 2) != 0);
      end
      send_random_name();
    end
    s_tvalid <= 1'b0;

    // Drain, then keep watching the output so that stray items show
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/u16u8_pkg.sv
rtl/u16u8_decode.sv
rtl/utf16_to_utf8_transcoder.sv
tb/utf16_to_utf8_transcoder_test.sv
